@@ rtl/bale_pkg.sv @@
// Shared types, codes and sizes for the bounded array list engine.
package bale_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OP_W    = 3;
    localparam int INDEX_W = 6;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 6;
    localparam int CNTF_W  = 7;
    localparam int CAP_W   = 7;
    localparam int HEUR_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CMP_A   = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int CMP_W   = (CMP_A > CAP_W) ? CMP_A : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    typedef enum logic [0:0] {
        REG_CAPACITY  = 1'b0,
        REG_HEURISTIC = 1'b1
    } t_reg;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_READ   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_SEARCH = 3'd4,
        OP_SORTED = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2,
        STAT_MISS  = 2'd3
    } t_status;

    typedef enum logic [HEUR_W-1:0] {
        HEUR_NONE  = 2'd0,
        HEUR_FWD   = 2'd1,
        HEUR_FRONT = 2'd2
    } t_heur;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    // command broadcast to every cell
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [CMP_W-1:0]         idx;
        logic signed [DATA_W-1:0] key;
        logic [CMP_W-1:0]         n;
        logic [HEUR_W-1:0]        heur;
        logic                     go;
        logic                     found;
    } t_cell_cmd;

    // left-to-right chain
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     sfx;
        logic                     any;
        logic signed [DATA_W-1:0] rd;
        logic [IDX_W-1:0]         pos;
    } t_lr;

    // right-to-left chain
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     sfx;
        logic                     first;
    } t_rl;

endpackage

@@ rtl/bale_if.sv @@
// Valid/ready channel interfaces for operation items and result items.
interface bale_in_if;
    import bale_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic [INDEX_W-1:0]        index;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output operation, output index, output value, input ready);
    modport sink   (input valid, input operation, input index, input value, output ready);
endinterface

interface bale_out_if;
    import bale_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic signed [DATA_W-1:0]  data_out;
    logic [POS_W-1:0]          position;
    logic [CNTF_W-1:0]         count;

    modport source (output valid, output status, output data_out, output position,
                    output count, input ready);
    modport sink   (input valid, input status, input data_out, input position,
                    input count, output ready);
endinterface

@@ rtl/bale_cell.sv @@
// One list slot: holds an entry and moves it to or from its neighbors.
module bale_cell (
    input  logic               i_clk,
    input  logic [bale_pkg::IDX_W-1:0] i_pos,
    input  bale_pkg::t_cell_cmd i_cmd,
    input  bale_pkg::t_lr      i_left,
    input  bale_pkg::t_rl      i_right,
    input  logic signed [bale_pkg::DATA_W-1:0] i_head,
    output bale_pkg::t_lr      o_lr,
    output bale_pkg::t_rl      o_rl
);
    import bale_pkg::*;

    logic signed [DATA_W-1:0] r_value, n_value;
    logic [CMP_W-1:0]         pos_c;
    logic in_list, beyond, not_past_end, sel, match, first, lt, sfx, ins_here, mark;

    always_comb begin
        pos_c        = CMP_W'(i_pos);
        in_list      = pos_c < i_cmd.n;
        beyond       = !in_list;
        not_past_end = pos_c <= i_cmd.n;
        sel          = pos_c == i_cmd.idx;
        match        = in_list && (r_value == i_cmd.key);
        first        = match && !i_left.any;
        lt           = i_cmd.key < r_value;
        // suffix of entries all greater than the key
        sfx          = beyond || (lt && i_right.sfx);
        ins_here     = sfx && !i_left.sfx;
        mark         = (i_cmd.op == OP_SEARCH) ? first : ins_here;
    end

    always_comb begin
        o_lr.value = r_value;
        o_lr.sfx   = sfx;
        o_lr.any   = i_left.any || match;
        o_lr.rd    = i_left.rd | (sel ? r_value : '0);
        o_lr.pos   = i_left.pos | (mark ? i_pos : '0);
        o_rl.value = r_value;
        o_rl.sfx   = sfx;
        o_rl.first = first;
    end

    always_comb begin
        n_value = r_value;
        if (i_cmd.go) begin
            unique case (i_cmd.op)
                OP_INSERT: begin
                    if (sel) begin
                        n_value = i_cmd.key;
                    end else if (pos_c > i_cmd.idx && not_past_end) begin
                        n_value = i_left.value;
                    end
                end
                OP_DELETE: begin
                    if (pos_c >= i_cmd.idx && (pos_c + CMP_W'(1)) < i_cmd.n) begin
                        n_value = i_right.value;
                    end
                end
                OP_WRITE: begin
                    if (sel) begin
                        n_value = i_cmd.key;
                    end
                end
                OP_SEARCH: begin
                    unique case (i_cmd.heur)
                        HEUR_FWD: begin
                            if (i_right.first) begin
                                n_value = i_cmd.key;
                            end else if (first && pos_c != '0) begin
                                n_value = i_left.value;
                            end
                        end
                        HEUR_FRONT: begin
                            if (pos_c == '0 && i_cmd.found) begin
                                n_value = i_cmd.key;
                            end else if (first) begin
                                n_value = i_head;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_SORTED: begin
                    if (ins_here) begin
                        n_value = i_cmd.key;
                    end else if (i_left.sfx && not_past_end) begin
                        n_value = i_left.value;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

@@ rtl/bale_ctrl.sv @@
// Sequencer: takes an item, drives the cell row, builds and holds the result.
module bale_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    bale_in_if.sink            i_in,
    bale_out_if.source         o_out,
    input  logic [bale_pkg::CAP_W-1:0]  i_cap,
    input  logic [bale_pkg::HEUR_W-1:0] i_heur,
    input  bale_pkg::t_lr      i_chain,
    output bale_pkg::t_cell_cmd o_cmd
);
    import bale_pkg::*;

    t_state                   r_state, n_state;
    logic [OP_W-1:0]          r_op;
    logic [CMP_W-1:0]         r_idx;
    logic signed [DATA_W-1:0] r_key;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid;
    logic [STAT_W-1:0]        r_status;
    logic signed [DATA_W-1:0] r_data;
    logic [POS_W-1:0]         r_position;
    logic [CNTF_W-1:0]        r_cnt_out;

    logic in_ready, exec, fire, ok, full;
    logic [CMP_W-1:0]         n_ext, cap_eff;
    t_status                  status;
    logic signed [DATA_W-1:0] data;
    logic [IDX_W-1:0]         pos;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_EXEC;
            S_EXEC: if (fire) n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        exec     = 1'b0;
        unique case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_EXEC: exec     = 1'b1;
        endcase
    end

    assign fire = exec && (!r_out_valid || o_out.ready);

    // result and new count
    always_comb begin
        n_ext   = CMP_W'(r_count);
        cap_eff = (CMP_W'(i_cap) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(i_cap);
        full    = n_ext >= cap_eff;
        status  = STAT_RANGE;
        data    = '0;
        pos     = '0;
        n_count = r_count;
        unique case (r_op)
            OP_INSERT: begin
                if (r_idx > n_ext) begin
                    status = STAT_RANGE;
                end else if (full) begin
                    status = STAT_FULL;
                end else begin
                    status  = STAT_OK;
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_DELETE: begin
                if (r_idx < n_ext) begin
                    status  = STAT_OK;
                    data    = i_chain.rd;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (r_idx < n_ext) begin
                    status = STAT_OK;
                    data   = i_chain.rd;
                end
            end
            OP_WRITE: begin
                if (r_idx < n_ext) begin
                    status = STAT_OK;
                end
            end
            OP_SEARCH: begin
                if (i_chain.any) begin
                    status = STAT_OK;
                    pos    = i_chain.pos;
                end else begin
                    status = STAT_MISS;
                end
            end
            OP_SORTED: begin
                if (full) begin
                    status = STAT_FULL;
                end else begin
                    status  = STAT_OK;
                    pos     = i_chain.pos;
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: status = STAT_RANGE;
        endcase
        ok = status == STAT_OK;
    end

    always_comb begin
        o_cmd.op    = r_op;
        o_cmd.idx   = r_idx;
        o_cmd.key   = r_key;
        o_cmd.n     = n_ext;
        o_cmd.heur  = i_heur;
        o_cmd.go    = fire && ok;
        o_cmd.found = i_chain.any;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_op  <= i_in.operation;
            r_idx <= CMP_W'(i_in.index);
            r_key <= i_in.value;
        end
        if (fire) begin
            r_status   <= status;
            r_data     <= data;
            r_position <= POS_W'(pos);
            r_cnt_out  <= CNTF_W'(n_count);
        end
    end

    assign i_in.ready     = in_ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.data_out = r_data;
    assign o_out.position = r_position;
    assign o_out.count    = r_cnt_out;

    a_fire_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_state == S_IDLE)
        else $error("sequencer did not return to idle after executing");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_count))
        else $error("entry count moved without an executed item");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && ok && (r_op == OP_INSERT || r_op == OP_SORTED))
        |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("successful insert did not grow the list");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("result appeared without an execute cycle");

endmodule

@@ rtl/bounded_array_list_engine_core.sv @@
// Top level of the bounded array list engine: register port, sequencer, cell row.
//
// Usage:
//   i_in  carries one operation item (operation, index, value); o_out returns one
//   result item (status, data_out, position, count) per accepted item. Both use
//   valid/ready; an item moves on a rising edge with valid and ready high.
//   Each list entry lives in its own cell. Cells pass values, search flags,
//   sorted-insert flags, read data and positions to their neighbors, so every
//   shift, swap and compare over the whole list settles within the execute cycle.
//   An item is taken in the capture state, then executed across the cell row in
//   the execute state; a new item is accepted only after the last one executed.
//   i_in.ready is high in the capture state even while a result waits in the
//   output register; if o_out is stalled, the execute cycle waits until the
//   output register is free, and nothing is lost.
//   Reset (i_rst_n low, synchronous) empties the list, sets capacity_limit to
//   64 and search_heuristic to 0. Entry storage is not cleared; only slots
//   below the count are ever read.
//   Registers (APB, write on psel & penable & pwrite): 0x0 capacity_limit,
//   0x4 search_heuristic. Write them only while the block is idle.
module bounded_array_list_engine_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bale_in_if.sink                       i_in,
    bale_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bale_pkg::PADDR_W-1:0]  paddr,
    input  logic [bale_pkg::PDATA_W-1:0]  pwdata,
    output logic [bale_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import bale_pkg::*;

    logic [CAP_W-1:0]  r_cap;
    logic [HEUR_W-1:0] r_heur;
    logic              cfg_wr;
    t_cell_cmd         cmd;
    t_lr               lr [DEPTH+1];
    t_rl               rl [DEPTH+1];

    // register port: byte address 4*i selects register i
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= CAP_RESET;
            r_heur <= HEUR_NONE;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[2]))
                REG_CAPACITY:  r_cap  <= pwdata[CAP_W-1:0];
                REG_HEURISTIC: r_heur <= pwdata[HEUR_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[2]))
            REG_CAPACITY:  prdata = PDATA_W'(r_cap);
            REG_HEURISTIC: prdata = PDATA_W'(r_heur);
        endcase
    end

    bale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cap   (r_cap),
        .i_heur  (r_heur),
        .i_chain (lr[DEPTH]),
        .o_cmd   (cmd)
    );

    // chain ends: nothing to the left of slot 0, an "all greater" suffix past the end
    always_comb begin
        lr[0].value = '0;
        lr[0].sfx   = 1'b0;
        lr[0].any   = 1'b0;
        lr[0].rd    = '0;
        lr[0].pos   = '0;
        rl[DEPTH].value = '0;
        rl[DEPTH].sfx   = 1'b1;
        rl[DEPTH].first = 1'b0;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bale_cell u_cell (
            .i_clk   (i_clk),
            .i_pos   (IDX_W'(g)),
            .i_cmd   (cmd),
            .i_left  (lr[g]),
            .i_right (rl[g+1]),
            .i_head  (lr[1].value),
            .o_lr    (lr[g+1]),
            .o_rl    (rl[g])
        );
    end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the bounded array list engine.
`timescale 1ns / 1ps

module testbench;
    import bale_pkg::*;

    // Operation and heuristic codes the block must tolerate but the package does not name
    localparam logic [OP_W-1:0]   OP_UNUSED_LO = 3'd6;
    localparam logic [OP_W-1:0]   OP_UNUSED_HI = 3'd7;
    localparam logic [HEUR_W-1:0] HEUR_UNUSED  = 2'd3;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 190;
    localparam int LOCKSTEP_OPS = 30;
    localparam int MAX_REPORTS  = 50;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] val;
    } t_list_cmd;

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] data;
        logic [POS_W-1:0]         pos;
        logic [CNTF_W-1:0]        cnt;
    } t_list_reply;

    typedef enum {
        MIX_GROW,
        MIX_SHRINK,
        MIX_SORTED
    } t_op_mix;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    bale_in_if  in_ch ();
    bale_out_if out_ch ();

    bounded_array_list_engine_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the list and its registers
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] list_words [DEPTH];
    int                       list_len;
    logic [CAP_W-1:0]         cap_reg;
    logic [HEUR_W-1:0]        heur_reg;

    t_list_cmd   cmd_queue [$];       // items waiting for the driver
    t_list_reply awaited_replies [$]; // predicted results, oldest first

    int mismatches;
    int results_seen;

    // handshake flags sampled at the rising edge, consumed at the falling edge
    bit in_fire;
    bit out_fire;
    int gap_left;
    int stall_left;
    int in_gap_max;
    int out_stall_max;

    // Works out the result of one operation and updates the shadow list.
    function automatic t_list_reply apply_list_op(logic [OP_W-1:0] op,
                                                  logic [INDEX_W-1:0] idx,
                                                  logic signed [DATA_W-1:0] val);
        t_list_reply              r;
        int                       n;
        int                       cap;
        int                       ix;
        int                       i;
        logic signed [DATA_W-1:0] t;
        r.status = STAT_OK;
        r.data   = '0;
        r.pos    = '0;
        n        = list_len;
        ix       = int'(idx);
        cap      = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        case (op)
            OP_INSERT: begin
                // range is checked before full
                if (ix > n) begin
                    r.status = STAT_RANGE;
                end else if (n >= cap) begin
                    r.status = STAT_FULL;
                end else begin
                    for (i = n; i > ix; i--)
                        list_words[i] = list_words[i-1];
                    list_words[ix] = val;
                    n++;
                end
            end
            OP_DELETE: begin
                if (ix >= n) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.data = list_words[ix];
                    for (i = ix; i + 1 < n; i++)
                        list_words[i] = list_words[i+1];
                    n--;
                end
            end
            OP_READ: begin
                if (ix >= n)
                    r.status = STAT_RANGE;
                else
                    r.data = list_words[ix];
            end
            OP_WRITE: begin
                if (ix >= n)
                    r.status = STAT_RANGE;
                else
                    list_words[ix] = val;
            end
            OP_SEARCH: begin
                r.status = STAT_MISS;
                for (i = 0; i < n; i++) begin
                    if (list_words[i] == val) begin
                        r.status = STAT_OK;
                        r.pos    = POS_W'(i);
                        t        = list_words[i];
                        // heuristic code 3 falls through as no move
                        if (heur_reg == HEUR_FWD && i != 0) begin
                            list_words[i]   = list_words[i-1];
                            list_words[i-1] = t;
                        end else if (heur_reg == HEUR_FRONT) begin
                            list_words[i] = list_words[0];
                            list_words[0] = t;
                        end
                        break;
                    end
                end
            end
            OP_SORTED: begin
                if (n >= cap) begin
                    r.status = STAT_FULL;
                end else begin
                    // lands after every equal entry
                    i = n;
                    while (i > 0 && val < list_words[i-1]) begin
                        list_words[i] = list_words[i-1];
                        i--;
                    end
                    list_words[i] = val;
                    r.pos = POS_W'(i);
                    n++;
                end
            end
            default: r.status = STAT_RANGE;
        endcase
        list_len = n;
        r.cnt    = CNTF_W'(n);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        if (mismatches < MAX_REPORTS)
            $display("%0t ns: result %0d %s: got %0h, expected %0h",
                     $time, results_seen, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Rising edge: take accepted items into the predictor, check results
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_list_reply want;
        in_fire  = i_rst_n && in_ch.valid && in_ch.ready;
        out_fire = i_rst_n && out_ch.valid && out_ch.ready;
        if (out_fire) begin
            results_seen++;
            if (awaited_replies.size() == 0) begin
                note_mismatch("arrived with nothing pending", out_ch.data_out, '0);
            end else begin
                want = awaited_replies.pop_front();
                if (out_ch.status !== want.status)
                    note_mismatch("status", DATA_W'(out_ch.status), DATA_W'(want.status));
                if (out_ch.data_out !== want.data)
                    note_mismatch("data_out", out_ch.data_out, want.data);
                if (out_ch.position !== want.pos)
                    note_mismatch("position", DATA_W'(out_ch.position), DATA_W'(want.pos));
                if (out_ch.count !== want.cnt)
                    note_mismatch("count", DATA_W'(out_ch.count), DATA_W'(want.cnt));
            end
        end
        if (in_fire)
            awaited_replies.push_back(apply_list_op(in_ch.operation, in_ch.index,
                                                    in_ch.value));
    end

    // ------------------------------------------------------------------
    // Falling edge: item driver with a random gap before each item
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_list_cmd c;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (gap_left > 0) begin
                in_ch.valid <= 1'b0;
                gap_left--;
            end else if (cmd_queue.size() != 0) begin
                c = cmd_queue.pop_front();
                in_ch.operation <= c.op;
                in_ch.index     <= c.idx;
                in_ch.value     <= c.val;
                in_ch.valid     <= 1'b1;
                gap_left = $urandom_range(0, in_gap_max);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Falling edge: result receiver, drops ready for a random stall after each result
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_fire)
                stall_left = $urandom_range(0, out_stall_max);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_op(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val);
        t_list_cmd c;
        c.op  = op;
        c.idx = idx;
        c.val = val;
        cmd_queue.push_back(c);
    endtask

    // Block is idle once nothing is queued, offered or outstanding.
    task automatic wait_idle();
        while (cmd_queue.size() != 0 || in_ch.valid || awaited_replies.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic reg_write(input t_reg r, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(r));
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_CAPACITY:  cap_reg  = data[CAP_W-1:0];
            REG_HEURISTIC: heur_reg = data[HEUR_W-1:0];
        endcase
    endtask

    // Small values dominate so that searches hit and sorted inserts meet equal keys.
    function automatic logic signed [DATA_W-1:0] draw_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5) begin
            return int'($urandom_range(0, 16)) - 8;
        end else if (sel == 5) begin
            case ($urandom_range(0, 3))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] draw_op(t_op_mix mix);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 97)
            return r[0] ? OP_UNUSED_HI : OP_UNUSED_LO;
        case (mix)
            MIX_GROW: begin
                if (r < 30) return OP_INSERT;
                if (r < 50) return OP_SORTED;
                if (r < 60) return OP_DELETE;
                if (r < 70) return OP_READ;
                if (r < 80) return OP_WRITE;
                return OP_SEARCH;
            end
            MIX_SHRINK: begin
                if (r < 10) return OP_INSERT;
                if (r < 15) return OP_SORTED;
                if (r < 55) return OP_DELETE;
                if (r < 67) return OP_READ;
                if (r < 77) return OP_WRITE;
                return OP_SEARCH;
            end
            default: begin
                if (r < 45) return OP_SORTED;
                if (r < 70) return OP_SEARCH;
                if (r < 88) return OP_DELETE;
                return OP_READ;
            end
        endcase
    endfunction

    // One random item shaped by the current shadow length.
    task automatic queue_random_op(input t_op_mix mix);
        logic [OP_W-1:0]          op;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] val;
        op = draw_op(mix);
        // mostly in range or one past the end; the rest anywhere in the field
        if ($urandom_range(0, 99) < 85)
            idx = INDEX_W'($urandom_range(0, (list_len > 63) ? 63 : list_len));
        else
            idx = INDEX_W'($urandom_range(0, 63));
        if (op == OP_SEARCH && list_len > 0 && $urandom_range(0, 1))
            val = list_words[$urandom_range(0, list_len - 1)];
        else
            val = draw_value();
        queue_op(op, idx, val);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [CAP_W-1:0]  phase_cap  [PHASES];
        logic [HEUR_W-1:0] phase_heur [PHASES];
        t_op_mix           mix;
        phase_cap  = '{7'd64, 7'd8, 7'd1, 7'd127, 7'd0, 7'd33, 7'd64, 7'd3};
        phase_heur = '{HEUR_NONE, HEUR_FWD, HEUR_FRONT, HEUR_UNUSED,
                       HEUR_FWD, HEUR_FRONT, HEUR_FWD, HEUR_NONE};

        // every input known from the start
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.operation = '0;
        in_ch.index     = '0;
        in_ch.value     = '0;
        out_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        mismatches      = 0;
        results_seen    = 0;
        gap_left        = 0;
        stall_left      = 0;
        in_gap_max      = 7;
        out_stall_max   = 7;

        // shadow state after reset
        foreach (list_words[i])
            list_words[i] = '0;
        list_len = 0;
        cap_reg  = CAP_RESET;
        heur_reg = HEUR_NONE;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, range edges, field extremes, unused codes
        queue_op(OP_SEARCH, 0, 0);
        queue_op(OP_READ, 0, 0);
        queue_op(OP_DELETE, 0, 0);
        queue_op(OP_WRITE, 0, 5);
        queue_op(OP_INSERT, 1, 7);           // past the end of an empty list
        queue_op(OP_INSERT, 0, WORD_MAX);
        queue_op(OP_INSERT, 1, WORD_MIN);    // append
        queue_op(OP_INSERT, 0, -1);
        queue_op(OP_INSERT, 63, 3);
        queue_op(OP_WRITE, 1, 0);
        queue_op(OP_READ, 1, 0);
        queue_op(OP_SORTED, 0, 5);
        queue_op(OP_SORTED, 63, WORD_MIN);   // lands after the equal entry
        queue_op(OP_SEARCH, 0, WORD_MIN);
        queue_op(OP_SEARCH, 0, 12345);
        queue_op(OP_DELETE, 0, 0);
        queue_op(OP_DELETE, 3, 0);           // last entry
        queue_op(OP_UNUSED_LO, 63, -1);
        queue_op(OP_UNUSED_HI, 0, 0);
        queue_op(OP_READ, 63, 0);
        wait_idle();

        // search heuristics on the entries now held
        reg_write(REG_HEURISTIC, PDATA_W'(HEUR_FWD));
        queue_op(OP_SEARCH, 0, list_words[list_len - 1]);
        wait_idle();
        reg_write(REG_HEURISTIC, PDATA_W'(HEUR_FRONT));
        queue_op(OP_SEARCH, 0, list_words[list_len - 1]);
        wait_idle();
        reg_write(REG_HEURISTIC, PDATA_W'(HEUR_UNUSED));
        queue_op(OP_SEARCH, 0, list_words[list_len - 1]);
        wait_idle();

        // zero capacity: every insert full, other ops still work
        reg_write(REG_CAPACITY, PDATA_W'(7'd0));
        queue_op(OP_INSERT, 0, 1);
        queue_op(OP_SORTED, 0, 1);
        queue_op(OP_READ, 0, 0);
        wait_idle();

        // capacity lowered under the count; range is reported before full
        reg_write(REG_CAPACITY, PDATA_W'(7'd2));
        queue_op(OP_INSERT, INDEX_W'(list_len), 9);
        queue_op(OP_INSERT, INDEX_W'(list_len + 2), 9);
        wait_idle();

        // capacity field at its maximum clamps to the depth
        reg_write(REG_CAPACITY, PDATA_W'(7'd127));
        queue_op(OP_INSERT, INDEX_W'(list_len), 9);
        wait_idle();

        // Random phases, each with its own register setting and idling pattern
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            reg_write(REG_CAPACITY, PDATA_W'(phase_cap[p]));
            reg_write(REG_HEURISTIC, PDATA_W'(phase_heur[p]));
            in_gap_max    = (p == 1 || p == 4) ? 0 : 7;
            out_stall_max = (p == 2 || p == 4) ? 0 : 7;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // keep the generator close to the shadow length
                while (cmd_queue.size() >= 2)
                    @(posedge i_clk);
                if (p == 6)
                    mix = MIX_GROW;               // fill to the depth
                else if (p == 5 && k >= 60)
                    mix = MIX_SORTED;
                else
                    mix = ((k / 48) % 2 != 0) ? MIX_SHRINK : MIX_GROW;
                queue_random_op(mix);
                // sender holds off until every result is back
                if (p == 2 && k < LOCKSTEP_OPS)
                    wait_idle();
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
